FILE: sv/cdt_pkg.sv
// cdt_pkg: shared widths, config and token types for the checkpoint dwell tracker.
// No dependencies; imported by every module of the block.
package cdt_pkg;

    localparam int NUM_DAMS      = 8;
    localparam int LENGTH_BITS   = 12;
    localparam int POSITION_BITS = 10;

    // Result item always carries eight dwell fields; slots at or above NUM_DAMS read zero.
    localparam int OUT_FIELDS  = 8;
    localparam int REG_COUNT   = 8;
    localparam int SLOT_BITS   = $clog2(OUT_FIELDS);
    localparam int CFG_IDX_BITS = $clog2(REG_COUNT);
    localparam int KEY_BITS    = POSITION_BITS + 1;

    localparam int IN_TDATA_W  = ((POSITION_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_FIELDS * LENGTH_BITS + 7) / 8) * 8;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    // Write strobe and data for one cell's checkpoint register.
    typedef struct packed {
        logic                     we;
        logic [POSITION_BITS-1:0] data;
    } cdt_cfg_t;

    // Token walking down the cell chain: up to two run closes per item,
    // plus the dwell slots gathered on the way for a last-day item.
    typedef struct packed {
        logic                                   valid;
        logic                                   last;
        logic                                   close1;
        logic [KEY_BITS-1:0]                    key1;
        logic [LENGTH_BITS-1:0]                 len1;
        logic                                   close2;
        logic [KEY_BITS-1:0]                    key2;
        logic [LENGTH_BITS-1:0]                 len2;
        logic [OUT_FIELDS-1:0][LENGTH_BITS-1:0] dwell;
    } cdt_token_t;

endpackage

FILE: sv/checkpoint_dwell_tracker_unit.sv
// checkpoint_dwell_tracker_unit: top level of the checkpoint dwell tracker.
// Depends on cdt_pkg, cdt_run_tracker and cdt_cell.
//
// Takes one end-of-day position per item (tdata[9:0], tlast marks the last
// day of a track) and run-length encodes it. Every run that closes is checked
// against the checkpoint positions written on the cfg port (index i =
// checkpoint i, zero = unused); a match with run position + 1 sets that
// checkpoint's dwell to the run length (saturating at 4095), later matches
// overwrite earlier ones. The last day of a track closes the final run and
// yields one result item holding all eight dwell counts; the block then
// starts the next track from a clean state. Rate: one item per clock while
// the chain is not stalled. From input to result an item passes a run
// tracker stage, one stage per checkpoint cell in the chain, and the output
// register. The chain stalls as a whole only while a result sits in the
// output register and the sink is not ready. Write cfg only while no track is
// moving through the chain.
module checkpoint_dwell_tracker_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_we,
    input  logic [cdt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [cdt_pkg::POSITION_BITS-1:0]  cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [cdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [9:0] position
    input  logic                               s_axis_tlast,  // last_day
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cdt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // delay_at_dam_0..7, 12b each
);
    import cdt_pkg::*;

    cdt_token_t                             chain [0:NUM_DAMS];
    logic                                   adv;
    logic                                   out_valid_reg, out_valid_next;
    logic [OUT_FIELDS-1:0][LENGTH_BITS-1:0] out_data_reg;
    cdt_token_t                             tail;

    // whole chain moves unless a result is stuck at the output
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    cdt_run_tracker u_run (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_axis_tvalid),
        .in_pos   (s_axis_tdata[POSITION_BITS-1:0]),
        .in_last  (s_axis_tlast),
        .tok      (chain[0])
    );

    // one cell per checkpoint; each owns its cfg register and dwell count
    for (genvar k = 0; k < NUM_DAMS; k++)
    begin : g_cell
        cdt_cfg_t cell_cfg;
        assign cell_cfg.we   = cfg_we && (cfg_index == CFG_IDX_BITS'(k));
        assign cell_cfg.data = cfg_data;

        cdt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .slot_id (SLOT_BITS'(k)),
            .cfg     (cell_cfg),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    assign tail = chain[NUM_DAMS];

    // only last-day tokens produce a result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = tail.valid && tail.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tail.valid && tail.last)
        begin
            out_data_reg <= tail.dwell;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(adv && tail.valid && tail.last))
        else $error("result item without a last-day token");

endmodule

FILE: sv/cdt_run_tracker.sv
// cdt_run_tracker: run-length encoder at the head of the chain.
// Depends on cdt_pkg; issues one token per accepted item.
module cdt_run_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [cdt_pkg::POSITION_BITS-1:0] in_pos,
    input  logic                              in_last,
    output cdt_pkg::cdt_token_t               tok
);
    import cdt_pkg::*;

    logic                     run_open_reg, run_open_next;
    logic [POSITION_BITS-1:0] run_pos_reg, run_pos_next;
    logic [LENGTH_BITS-1:0]   run_len_reg, run_len_next;
    cdt_token_t               tok_reg, tok_next;
    logic                     accept;
    logic [POSITION_BITS-1:0] new_pos;
    logic [LENGTH_BITS-1:0]   new_len;

    assign accept = in_valid && adv;

    always_comb
    begin
        tok_next        = '0;
        tok_next.valid  = accept;
        tok_next.last   = in_last;
        new_pos         = in_pos;
        new_len         = LEN_ONE;
        if (run_open_reg && (in_pos == run_pos_reg))
        begin
            new_len = (run_len_reg < LEN_MAX) ? run_len_reg + LEN_ONE : run_len_reg;
        end
        else if (run_open_reg)
        begin
            // position moved: the open run closes before the new one starts
            tok_next.close1 = 1'b1;
            tok_next.key1   = KEY_BITS'(run_pos_reg) + KEY_BITS'(1);
            tok_next.len1   = run_len_reg;
        end
        tok_next.close2 = in_last;
        tok_next.key2   = KEY_BITS'(new_pos) + KEY_BITS'(1);
        tok_next.len2   = new_len;

        run_open_next = run_open_reg;
        run_pos_next  = run_pos_reg;
        run_len_next  = run_len_reg;
        if (accept)
        begin
            run_open_next = !in_last;
            run_pos_next  = in_last ? '0 : new_pos;
            run_len_next  = in_last ? '0 : new_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            run_pos_reg  <= '0;
            run_len_reg  <= '0;
            tok_reg      <= '0;
        end
        else
        begin
            run_open_reg <= run_open_next;
            run_pos_reg  <= run_pos_next;
            run_len_reg  <= run_len_next;
            if (adv)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    assign tok = tok_reg;

    a_open_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg |-> (run_len_reg != '0))
        else $error("open run with zero length");

    a_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (!run_open_reg && tok_reg.valid && tok_reg.close2))
        else $error("last-day item did not close the run");

endmodule

FILE: sv/cdt_cell.sv
// cdt_cell: one checkpoint of the chain; holds its position and dwell count.
// Depends on cdt_pkg; consumes and forwards one token per advance.
module cdt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [cdt_pkg::SLOT_BITS-1:0] slot_id,
    input  cdt_pkg::cdt_cfg_t             cfg,
    input  cdt_pkg::cdt_token_t           tok_in,
    output cdt_pkg::cdt_token_t           tok_out
);
    import cdt_pkg::*;

    logic [POSITION_BITS-1:0] dam_reg;
    logic [LENGTH_BITS-1:0]   dwell_reg, dwell_next, dwell_upd;
    cdt_token_t               tok_reg, tok_next;
    logic                     hit1, hit2;

    assign hit1 = tok_in.close1 && (dam_reg != '0) && (KEY_BITS'(dam_reg) == tok_in.key1);
    assign hit2 = tok_in.close2 && (dam_reg != '0) && (KEY_BITS'(dam_reg) == tok_in.key2);

    always_comb
    begin
        // second close is the later run, so it wins
        dwell_upd = dwell_reg;
        if (hit1)
        begin
            dwell_upd = tok_in.len1;
        end
        if (hit2)
        begin
            dwell_upd = tok_in.len2;
        end
        tok_next                = tok_in;
        tok_next.dwell[slot_id] = dwell_upd;
        dwell_next              = dwell_reg;
        if (tok_in.valid)
        begin
            dwell_next = tok_in.last ? '0 : dwell_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dam_reg   <= '0;
            dwell_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            if (cfg.we)
            begin
                dam_reg <= cfg.data;
            end
            if (adv)
            begin
                dwell_reg <= dwell_next;
                tok_reg   <= tok_next;
            end
        end
    end

    assign tok_out = tok_reg;

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && tok_in.valid && tok_in.last) |=> (dwell_reg == '0))
        else $error("dwell count not cleared after track end");

endmodule
